// File: rtl/ptrt_pkg.sv
// Shared types and constants for the periodic task release timer.
package ptrt_pkg;

	// Slot count and derived widths
	localparam int TASK_COUNT = 8;
	localparam int SLOT_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int MASK_W     = 8;
	localparam int ACT_LANES  = (TASK_COUNT < MASK_W) ? TASK_COUNT : MASK_W;
	localparam int TIME_W     = 16;
	localparam int CNT_W      = 8;

	localparam logic [TIME_W-1:0] IDLE_COMPARE = 16'hFFFF;

	typedef enum logic [1:0] {
		REQ_REGISTER   = 2'd0,
		REQ_UNREGISTER = 2'd1,
		REQ_COMPARE    = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BOUNDS      = 2'd1,
		ST_ZERO_PERIOD = 2'd2,
		ST_BUSY        = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_slot;
	} dp_sts_t;

endpackage

// File: rtl/ptrt_if.sv
// Request and response channel interfaces of the release timer.
interface ptrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  task_index;
	logic [15:0] phase;
	logic [15:0] period;
	logic [7:0]  active_mask;

	modport source (output valid, req_type, task_index, phase, period, active_mask,
		input ready);
	modport sink (input valid, req_type, task_index, phase, period, active_mask,
		output ready);
endinterface

interface ptrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] next_compare;
	logic [7:0]  released_mask;
	logic        sched_call;

	modport source (output valid, status, next_compare, released_mask, sched_call,
		input ready);
	modport sink (input valid, status, next_compare, released_mask, sched_call,
		output ready);
endinterface

// File: rtl/ptrt_ctrl.sv
// Controller state machine: accept, walk the slots for a compare, commit the result.
module ptrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_type,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ptrt_pkg::dp_cmd_t cmd,
	input  ptrt_pkg::dp_sts_t sts
);
	import ptrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WALK   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (req_type == REQ_COMPARE) begin
						state_nxt = S_WALK;
					end else begin
						state_nxt = S_FINISH;
					end
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.last_slot) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= cmd.commit || (rsp_valid_q && !rsp_ready);
		end
	end

endmodule

// File: rtl/ptrt_dp.sv
// Datapath: slot tables, compare walk, and the result register.
module ptrt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ptrt_pkg::dp_cmd_t cmd,
	output ptrt_pkg::dp_sts_t sts,
	input  logic [1:0]        req_type,
	input  logic [3:0]        task_index,
	input  logic [15:0]       phase,
	input  logic [15:0]       period,
	input  logic [7:0]        active_mask,
	output logic [1:0]        status,
	output logic [15:0]       next_compare,
	output logic [7:0]        released_mask,
	output logic              sched_call
);
	import ptrt_pkg::*;

	// Latched request
	logic [1:0]        type_q;
	logic [3:0]        idx_q;
	logic [15:0]       phase_q;
	logic [15:0]       period_q;
	logic [MASK_W-1:0] amask_q;

	// Slot tables
	logic [TASK_COUNT-1:0] in_use_q;
	logic [CNT_W-1:0]      act_q [TASK_COUNT];
	logic [TIME_W-1:0]     nr_q  [TASK_COUNT];
	logic [TIME_W-1:0]     per_q [TASK_COUNT];
	logic [TIME_W-1:0]     cur_q;

	// Walk state
	logic [SLOT_W-1:0] cnt_q;
	logic [MASK_W-1:0] rmask_q;
	logic              any_q;
	logic [TIME_W-1:0] best_q;
	logic              found_q;
	logic [SLOT_W-1:0] low_new_q;

	// Result register
	logic [1:0]        status_q;
	logic [TIME_W-1:0] nc_q;
	logic [MASK_W-1:0] rm_q;
	logic              call_q;

	logic [SLOT_W-1:0] slot_w;
	logic              idx_ok;
	logic [TIME_W-1:0] scaled_ph;
	logic [TIME_W-1:0] scaled_per;
	status_t           reg_status;
	logic              reg_ok;
	logic [TIME_W-1:0] cur_nr;
	logic              hit;
	logic [TIME_W-1:0] adv;
	logic              take;
	logic [TIME_W-1:0] walk_next;
	logic              act_found;
	logic [SLOT_W-1:0] low_act;
	logic              call_nxt;

	// Decode register request
	assign slot_w     = idx_q[SLOT_W-1:0];
	assign idx_ok     = int'(idx_q) < TASK_COUNT;
	assign scaled_ph  = {phase_q[13:0], 2'b00};
	assign scaled_per = {period_q[13:0], 2'b00};

	always_comb begin
		if (!idx_ok) begin
			reg_status = ST_BOUNDS;
		end else if (scaled_per == '0) begin
			reg_status = ST_ZERO_PERIOD;
		end else if (in_use_q[slot_w]) begin
			reg_status = ST_BUSY;
		end else begin
			reg_status = ST_OK;
		end
	end

	assign reg_ok = cmd.commit && (type_q == REQ_REGISTER) && (reg_status == ST_OK);

	// Examine the slot under the walk counter
	assign cur_nr    = nr_q[cnt_q];
	assign hit       = in_use_q[cnt_q] && (cur_nr == cur_q);
	assign adv       = hit ? (cur_nr + per_q[cnt_q]) : cur_nr;
	assign take      = in_use_q[cnt_q] && (!any_q || (adv < best_q));
	assign walk_next = any_q ? best_q : IDLE_COMPARE;

	assign sts.last_slot = (cnt_q == SLOT_W'(TASK_COUNT - 1));

	// Find the lowest active slot
	always_comb begin
		act_found = 1'b0;
		low_act   = '0;
		for (int j = ACT_LANES - 1; j >= 0; j--) begin
			if (amask_q[j]) begin
				act_found = 1'b1;
				low_act   = SLOT_W'(j);
			end
		end
	end

	assign call_nxt = !act_found || (found_q && (low_new_q < low_act));

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q   <= req_type;
			idx_q    <= task_index;
			phase_q  <= phase;
			period_q <= period;
			amask_q  <= active_mask;
		end
	end

	// Advance the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rmask_q   <= '0;
			any_q     <= 1'b0;
			best_q    <= '0;
			found_q   <= 1'b0;
			low_new_q <= '0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			rmask_q <= '0;
			any_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + SLOT_W'(1);
			for (int j = 0; j < MASK_W; j++) begin
				if (hit && (int'(cnt_q) == j)) begin
					rmask_q[j] <= 1'b1;
				end
			end
			if (hit && !found_q) begin
				found_q   <= 1'b1;
				low_new_q <= cnt_q;
			end
			if (take) begin
				any_q  <= 1'b1;
				best_q <= adv;
			end
		end
	end

	// Update release times and periods
	always_ff @(posedge clk) begin
		if (cmd.step && hit) begin
			nr_q[cnt_q] <= adv;
		end else if (reg_ok) begin
			nr_q[slot_w]  <= scaled_ph;
			per_q[slot_w] <= scaled_per;
		end
	end

	// Update occupancy and activation counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				act_q[i] <= '0;
			end
		end else if (cmd.step && hit) begin
			act_q[cnt_q] <= act_q[cnt_q] + CNT_W'(1);
		end else if (reg_ok) begin
			in_use_q[slot_w] <= 1'b1;
			act_q[slot_w]    <= '0;
		end else if (cmd.commit && (type_q == REQ_UNREGISTER) && idx_ok) begin
			in_use_q[slot_w] <= 1'b0;
		end
	end

	// Hold the compare time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.commit && (type_q == REQ_COMPARE)) begin
			cur_q <= walk_next;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unique case (type_q)
				REQ_REGISTER: begin
					status_q <= reg_status;
					nc_q     <= cur_q;
					rm_q     <= '0;
					call_q   <= 1'b0;
				end
				REQ_UNREGISTER: begin
					status_q <= idx_ok ? ST_OK : ST_BOUNDS;
					nc_q     <= cur_q;
					rm_q     <= '0;
					call_q   <= 1'b0;
				end
				REQ_COMPARE: begin
					status_q <= ST_OK;
					nc_q     <= walk_next;
					rm_q     <= rmask_q;
					call_q   <= call_nxt;
				end
				default: begin
					status_q <= ST_OK;
					nc_q     <= cur_q;
					rm_q     <= '0;
					call_q   <= 1'b0;
				end
			endcase
		end
	end

	assign status        = status_q;
	assign next_compare  = nc_q;
	assign released_mask = rm_q;
	assign sched_call    = call_q;

endmodule

// File: rtl/periodic_task_release_timer_top.sv
// Top level of the periodic task release timer.
// Register, unregister and unused requests pass from accept to the result commit without a walk.
// A compare event is accepted, then walks the eight slots in turn through the
// shared add and compare unit, then commits the result.
// A new request waits for the last result to commit, which output stalls delay.
// Reset clears slot occupancy, activation counts and the compare time to zero.
module periodic_task_release_timer_top (
	input logic        clk,
	input logic        arst_n,
	ptrt_req_if.sink   req,
	ptrt_rsp_if.source rsp
);
	import ptrt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller
	ptrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath
	ptrt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.task_index    (req.task_index),
		.phase         (req.phase),
		.period        (req.period),
		.active_mask   (req.active_mask),
		.status        (rsp.status),
		.next_compare  (rsp.next_compare),
		.released_mask (rsp.released_mask),
		.sched_call    (rsp.sched_call)
	);

endmodule

// File: rtl/ptrt_checker.sv
// Port-level checks for the release timer, bound to the top level.
module ptrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [15:0] next_compare,
	input logic [7:0]  released_mask,
	input logic        sched_call
);
	import ptrt_pkg::*;

	// One request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted back to back");

	// Released slots only come from a compare event, which reports success
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (released_mask != '0) |-> status == ST_OK)
		else $error("release reported with failing status");

	// A scheduler call only comes from a compare event
	a_call_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sched_call |-> status == ST_OK)
		else $error("scheduler call reported with failing status");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(next_compare) && $stable(released_mask) && $stable(sched_call))
		else $error("stalled response changed");

endmodule

bind periodic_task_release_timer_top ptrt_checker u_ptrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.next_compare  (rsp.next_compare),
	.released_mask (rsp.released_mask),
	.sched_call    (rsp.sched_call)
);
